FILE: hdl/fpcc_pkg.sv
`default_nettype none
package fpcc_pkg;
	localparam int MaxBlocks = 16;
	localparam int AesRounds = 10;

	localparam logic [3:0] AddrKeyHigh = 4'd0;
	localparam logic [3:0] AddrKeyLow  = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_OUT
	} state_t;

	typedef logic [7:0] byte_t;

	function automatic byte_t sbox(input byte_t v);
		byte_t r;
		case (v)
		8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
		8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
		8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
		8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
		8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
		8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
		8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
		8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
		8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
		8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
		8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
		8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
		8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
		8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
		8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
		8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
		8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
		8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
		8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
		8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
		8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
		8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
		8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
		8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
		8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
		8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
		8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
		8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
		8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
		8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
		8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
		8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
		8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
		8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
		8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
		8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
		8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
		8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
		8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
		8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
		8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
		8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
		8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
		8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
		8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
		8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
		8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
		8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
		8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
		8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
		8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
		8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
		8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
		8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
		8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
		8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
		8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
		8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
		8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
		8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
		8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
		8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
		8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
		8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
		default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic byte_t xtime(input byte_t v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction
endpackage
`default_nettype wire

FILE: hdl/fpcc_stream_if.sv
`default_nettype none
interface fpcc_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_in;
	logic        last_in;
	logic [31:0] frame_counter;
	logic        direction;
	logic [31:0] device_address;
	modport source (output valid, data_in, last_in, frame_counter, direction,
		device_address, input ready);
	modport sink (input valid, data_in, last_in, frame_counter, direction,
		device_address, output ready);
endinterface

interface fpcc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;
	logic       last_out;
	modport source (output valid, data_out, last_out, input ready);
	modport sink (input valid, data_out, last_out, output ready);
endinterface
`default_nettype wire

FILE: hdl/frame_payload_ctr_cipher_core.sv
`default_nettype none
// Byte-wise AES-128 counter-mode cipher for a frame payload. Each byte is
// one transfer in and one transfer out. A byte at the start of a 16-byte
// block runs one AES encryption on a single shared round unit (one round a
// cycle, key schedule on the fly) in the round state; its result is then
// offered in the output state. The other bytes of the block skip the round
// state: their result is registered on accept and offered in the next cycle.
// Ready returns only once the result is taken, so an output stall holds
// off the next byte. Key registers lie at byte addresses 0 (key_high) and
// 8 (key_low), 64 bits wide; a key written during a frame is used from the
// next block. Bytes past the block limit of a frame come out as zero.
module frame_payload_ctr_cipher_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	fpcc_in_if.sink           in_ch,
	fpcc_out_if.source        out_ch
);
	fpcc_pkg::state_t state_q, state_d;
	logic [63:0]  key_high_q, key_low_q;
	logic [127:0] ks_q;
	logic [127:0] st_q, rk_q;
	logic [3:0]   round_q;
	logic [7:0]   rcon_q;
	logic [3:0]   pos_q;
	logic [7:0]   blk_q;
	logic         in_frame_q;
	logic [31:0]  cnt_q, addr_q;
	logic         dir_q;
	logic [7:0]   data_q, res_q;
	logic         last_q;

	logic accept, wr_en;
	assign accept = in_ch.valid && in_ch.ready;
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_comb begin
		case (paddr)
		fpcc_pkg::AddrKeyHigh: prdata = key_high_q;
		fpcc_pkg::AddrKeyLow: prdata = key_low_q;
		default: prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= 64'd0;
			key_low_q <= 64'd0;
		end else if (wr_en) begin
			if (paddr == fpcc_pkg::AddrKeyHigh) key_high_q <= pwdata;
			if (paddr == fpcc_pkg::AddrKeyLow) key_low_q <= pwdata;
		end
	end

	// effective frame parameters for the accepted byte
	logic [31:0] cnt_e, addr_e;
	logic        dir_e;
	logic [7:0]  blk_e;
	logic [3:0]  pos_e;
	always_comb begin
		if (in_frame_q) begin
			cnt_e = cnt_q; addr_e = addr_q; dir_e = dir_q;
			blk_e = blk_q; pos_e = pos_q;
		end else begin
			cnt_e = in_ch.frame_counter; addr_e = in_ch.device_address;
			dir_e = in_ch.direction; blk_e = 8'd1; pos_e = 4'd0;
		end
	end

	logic [127:0] ctr_blk, key_w;
	assign key_w = {key_high_q, key_low_q};
	assign ctr_blk = {8'h01, 32'd0, 7'd0, dir_e,
		addr_e[7:0], addr_e[15:8], addr_e[23:16], addr_e[31:24],
		cnt_e[7:0], cnt_e[15:8], cnt_e[23:16], cnt_e[31:24], 8'd0, blk_e};

	// shared round unit: byte k of the state sits in bits 127-8k
	logic [127:0] rk_n, st_n, sb, sr, mc;
	always_comb begin
		logic [31:0] w0, w1, w2, w3, t;
		w0 = rk_q[127:96]; w1 = rk_q[95:64]; w2 = rk_q[63:32]; w3 = rk_q[31:0];
		t = {fpcc_pkg::sbox(w3[23:16]) ^ rcon_q, fpcc_pkg::sbox(w3[15:8]),
			fpcc_pkg::sbox(w3[7:0]), fpcc_pkg::sbox(w3[31:24])};
		w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
		rk_n = {w0, w1, w2, w3};
	end
	always_comb begin
		for (int k = 0; k < 16; k++)
			sb[127-8*k -: 8] = fpcc_pkg::sbox(st_q[127-8*k -: 8]);
		for (int c = 0; c < 4; c++)
			for (int j = 0; j < 4; j++)
				sr[127-8*(j+4*c) -: 8] = sb[127-8*(j+4*((c+j)%4)) -: 8];
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3, al;
			a0 = sr[127-32*c -: 8]; a1 = sr[119-32*c -: 8];
			a2 = sr[111-32*c -: 8]; a3 = sr[103-32*c -: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			mc[127-32*c -: 8] = a0 ^ al ^ fpcc_pkg::xtime(a0 ^ a1);
			mc[119-32*c -: 8] = a1 ^ al ^ fpcc_pkg::xtime(a1 ^ a2);
			mc[111-32*c -: 8] = a2 ^ al ^ fpcc_pkg::xtime(a2 ^ a3);
			mc[103-32*c -: 8] = a3 ^ al ^ fpcc_pkg::xtime(a3 ^ a0);
		end
		st_n = ((round_q == 4'(fpcc_pkg::AesRounds)) ? sr : mc) ^ rk_n;
	end

	logic need_ks;
	assign need_ks = (blk_e != 8'd0) && (pos_e == 4'd0);

	always_comb begin
		case (state_q)
		fpcc_pkg::ST_IDLE:
			state_d = accept ? (need_ks ? fpcc_pkg::ST_ROUND : fpcc_pkg::ST_OUT)
				: fpcc_pkg::ST_IDLE;
		fpcc_pkg::ST_ROUND:
			state_d = (round_q == 4'(fpcc_pkg::AesRounds)) ? fpcc_pkg::ST_OUT
				: fpcc_pkg::ST_ROUND;
		fpcc_pkg::ST_OUT:
			state_d = out_ch.ready ? fpcc_pkg::ST_IDLE : fpcc_pkg::ST_OUT;
		default: state_d = fpcc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = (state_q == fpcc_pkg::ST_IDLE);
		out_ch.valid = (state_q == fpcc_pkg::ST_OUT);
		out_ch.data_out = res_q;
		out_ch.last_out = last_q;
	end

	logic [7:0] ks_byte;
	logic [3:0] use_pos;
	logic       use_ok;
	logic [127:0] ks_cur;
	assign ks_cur = (state_q == fpcc_pkg::ST_ROUND) ? st_n : ks_q;
	assign ks_byte = ks_cur[127 - 8*use_pos -: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpcc_pkg::ST_IDLE;
			in_frame_q <= 1'b0;
			pos_q <= 4'd0;
			blk_q <= 8'd1;
			cnt_q <= 32'd0;
			addr_q <= 32'd0;
			dir_q <= 1'b0;
			ks_q <= 128'd0;
			st_q <= 128'd0;
			rk_q <= 128'd0;
			round_q <= 4'd0;
			rcon_q <= 8'h01;
			use_pos <= 4'd0;
			use_ok <= 1'b0;
			data_q <= 8'd0;
			res_q <= 8'd0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= cnt_e; addr_q <= addr_e; dir_q <= dir_e;
				data_q <= in_ch.data_in;
				last_q <= in_ch.last_in;
				use_pos <= pos_e;
				use_ok <= (blk_e != 8'd0);
				st_q <= ctr_blk ^ key_w;
				rk_q <= key_w;
				round_q <= 4'd1;
				rcon_q <= 8'h01;
				if (in_ch.last_in) begin
					in_frame_q <= 1'b0; pos_q <= 4'd0; blk_q <= 8'd1;
				end else begin
					in_frame_q <= 1'b1;
					pos_q <= (blk_e != 8'd0) ? pos_e + 4'd1 : pos_e;
					blk_q <= blk_e;
					if (blk_e != 8'd0 && pos_e == 4'd15)
						blk_q <= (blk_e >= 8'(fpcc_pkg::MaxBlocks)) ? 8'd0
							: blk_e + 8'd1;
				end
				if (!need_ks)
					res_q <= (blk_e != 8'd0) ? in_ch.data_in ^ ks_q[127 - 8*pos_e -: 8]
						: 8'd0;
			end
			if (state_q == fpcc_pkg::ST_ROUND) begin
				st_q <= st_n;
				rk_q <= rk_n;
				rcon_q <= fpcc_pkg::xtime(rcon_q);
				round_q <= round_q + 4'd1;
				if (round_q == 4'(fpcc_pkg::AesRounds)) begin
					ks_q <= st_n;
					res_q <= use_ok ? data_q ^ ks_byte : 8'd0;
				end
			end
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready)
		else $error("input taken while result pending");
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fpcc_pkg::ST_ROUND) |->
			(round_q >= 4'd1 && round_q <= 4'(fpcc_pkg::AesRounds)))
		else $error("round counter out of range");
	a_ks_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && need_ks) |=> (state_q == fpcc_pkg::ST_ROUND && round_q == 4'd1))
		else $error("block start did not run encryption");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_ch.last_in) |=> !in_frame_q)
		else $error("frame not closed on last byte");
endmodule
`default_nettype wire
